// ===== sv/delta_list_sleep_timer_queue_unit_defines.svh =====
// Assertion macros for the delta-list sleep timer queue.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef DELTA_LIST_SLEEP_TIMER_QUEUE_UNIT_DEFINES_SVH
`define DELTA_LIST_SLEEP_TIMER_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DLSTQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dlstq check failed");
`define DLSTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dlstq check failed");
`else
`define DLSTQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DLSTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/dlstq_pkg.sv =====
// Shared types and constants for the delta-list sleep timer queue.
// No dependencies; used by dlstq_cell and the top level.
package dlstq_pkg;

    localparam int DefaultMaxSleepers = 16;
    localparam int DefaultTimeBits    = 16;
    localparam int MaxResults         = 16;
    localparam int WakeCntW           = $clog2(MaxResults);

    localparam int FUNC_W  = 2;
    localparam int ID_W    = 8;
    localparam int TICKS_W = 16;
    localparam int KIND_W  = 2;

    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SLEEP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    localparam logic [KIND_W-1:0] KIND_DONE      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WOKEN     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_POP,
        OP_DEC
    } cell_op_t;

    typedef struct packed {
        cell_op_t        op;
        logic [ID_W-1:0] thread;
    } cell_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_WAKE
    } state_t;

endpackage

// ===== sv/dlstq_cell.sv =====
// One slot of the sleeper chain: valid, thread and remaining ticks to wake.
// Depends on dlstq_pkg; exchanges entries with its left and right neighbors.
module dlstq_cell #(
    parameter int TIME_BITS = dlstq_pkg::DefaultTimeBits
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dlstq_pkg::cell_cmd_t        cmd,
    input  logic [TIME_BITS-1:0]        ticks,
    input  logic                        left_valid,
    input  logic [dlstq_pkg::ID_W-1:0]  left_thread,
    input  logic [TIME_BITS-1:0]        left_cum,
    input  logic                        right_valid,
    input  logic [dlstq_pkg::ID_W-1:0]  right_thread,
    input  logic [TIME_BITS-1:0]        right_cum,
    input  logic                        le_in,
    input  logic                        hit_in,
    output logic                        valid,
    output logic [dlstq_pkg::ID_W-1:0]  thread,
    output logic [TIME_BITS-1:0]        cum,
    output logic                        le_out,
    output logic                        hit_out
);
    import dlstq_pkg::*;

    logic                 valid_reg, valid_next;
    logic [ID_W-1:0]      thread_reg, thread_next;
    logic [TIME_BITS-1:0] cum_reg, cum_next;
    logic                 match;

    // wake time stored relative to now; the chain is sorted ascending
    assign le_out  = valid_reg && (cum_reg <= ticks);
    assign match   = valid_reg && (thread_reg == cmd.thread);
    assign hit_out = hit_in || match;

    assign valid  = valid_reg;
    assign thread = thread_reg;
    assign cum    = cum_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        thread_next = thread_reg;
        cum_next    = cum_reg;
        unique case (cmd.op)
            OP_INSERT:
            begin
                if (!le_out)
                begin
                    if (le_in)
                    begin
                        valid_next  = 1'b1;
                        thread_next = cmd.thread;
                        cum_next    = ticks;
                    end
                    else
                    begin
                        valid_next  = left_valid;
                        thread_next = left_thread;
                        cum_next    = left_cum;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (hit_out)
                begin
                    valid_next  = right_valid;
                    thread_next = right_thread;
                    cum_next    = right_cum;
                end
            end
            OP_POP:
            begin
                valid_next  = right_valid;
                thread_next = right_thread;
                cum_next    = right_cum;
            end
            OP_DEC:
            begin
                if (valid_reg)
                begin
                    cum_next = cum_reg - TIME_BITS'(1);
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        thread_reg <= thread_next;
        cum_reg    <= cum_next;
    end

endmodule

// ===== sv/delta_list_sleep_timer_queue_unit.sv =====
// Top level of the delta-list sleep timer queue: chain of dlstq_cell slots,
// control FSM and result register. Depends on dlstq_pkg and the defines header.
//
//  channel  | valid / ready          | payload
//  ---------+------------------------+--------------------------------
//  request  | req_valid / req_ready  | func, thread_id, sleep_ticks
//  response | rsp_valid / rsp_ready  | kind, woken_id, last
//
// Sleep, remove, unused codes and a tick on an empty list finish on acceptance:
// the chain updates in place and the single result enters the output register.
// Any other tick ages the chain, then sends one WOKEN item per woken thread
// (one DONE if none wakes); the output register moves one item per cycle
// unless stalled. A stalled response holds the FSM; no clearing pass after reset.
`include "delta_list_sleep_timer_queue_unit_defines.svh"

module delta_list_sleep_timer_queue_unit #(
    parameter int MAX_SLEEPERS = dlstq_pkg::DefaultMaxSleepers,
    parameter int TIME_BITS    = dlstq_pkg::DefaultTimeBits
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic [dlstq_pkg::FUNC_W-1:0]   func,
    input  logic [dlstq_pkg::ID_W-1:0]     thread_id,
    input  logic [dlstq_pkg::TICKS_W-1:0]  sleep_ticks,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic [dlstq_pkg::KIND_W-1:0]   kind,
    output logic [dlstq_pkg::ID_W-1:0]     woken_id,
    output logic                           last
);
    import dlstq_pkg::*;

    localparam int N = MAX_SLEEPERS;

    logic [N-1:0]         valid_vec, le_vec, hit_vec;
    logic [ID_W-1:0]      thread_arr [N];
    logic [TIME_BITS-1:0] cum_arr [N];
    logic [TIME_BITS-1:0] ticks_c;
    cell_cmd_t            cmd;

    state_t               state_reg, state_next;
    logic [WakeCntW-1:0]  wake_cnt_reg, wake_cnt_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [ID_W-1:0]      woken_id_reg, woken_id_next;
    logic                 last_reg, last_next;

    logic out_free, accept, full, empty, found, head_zero, wake_last;

    assign ticks_c = TIME_BITS'(sleep_ticks);

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic                 lv, rv, lei, hii;
        logic [ID_W-1:0]      lt, rt;
        logic [TIME_BITS-1:0] lc, rc;

        if (i == 0)
        begin : g_head
            assign lv  = 1'b0;
            assign lt  = '0;
            assign lc  = '0;
            assign lei = 1'b1;
            assign hii = 1'b0;
        end
        else
        begin : g_mid
            assign lv  = valid_vec[i-1];
            assign lt  = thread_arr[i-1];
            assign lc  = cum_arr[i-1];
            assign lei = le_vec[i-1];
            assign hii = hit_vec[i-1];
        end

        if (i == N - 1)
        begin : g_tail
            assign rv = 1'b0;
            assign rt = '0;
            assign rc = '0;
        end
        else
        begin : g_body
            assign rv = valid_vec[i+1];
            assign rt = thread_arr[i+1];
            assign rc = cum_arr[i+1];
        end

        dlstq_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .ticks        (ticks_c),
            .left_valid   (lv),
            .left_thread  (lt),
            .left_cum     (lc),
            .right_valid  (rv),
            .right_thread (rt),
            .right_cum    (rc),
            .le_in        (lei),
            .hit_in       (hii),
            .valid        (valid_vec[i]),
            .thread       (thread_arr[i]),
            .cum          (cum_arr[i]),
            .le_out       (le_vec[i]),
            .hit_out      (hit_vec[i])
        );
    end

    assign full      = valid_vec[N-1];
    assign empty     = !valid_vec[0];
    assign found     = hit_vec[N-1];
    assign head_zero = valid_vec[0] && (cum_arr[0] == '0);
    assign wake_last = (wake_cnt_reg == WakeCntW'(MaxResults - 1))
                    || !valid_vec[1] || (cum_arr[1] != '0);

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign accept   = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (func == FUNC_TICK) && !empty)
                begin
                    state_next = ST_WAKE;
                end
            end
            ST_WAKE:
            begin
                if (out_free && (!head_zero || wake_last))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready      = 1'b0;
        cmd.op         = OP_HOLD;
        cmd.thread     = thread_id;
        wake_cnt_next  = wake_cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        kind_next      = kind_reg;
        woken_id_next  = woken_id_reg;
        last_next      = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = out_free;
                if (accept)
                begin
                    rsp_valid_next = 1'b1;
                    kind_next      = KIND_DONE;
                    woken_id_next  = '0;
                    last_next      = 1'b1;
                    wake_cnt_next  = '0;
                    unique case (func)
                        FUNC_TICK:
                        begin
                            if (!empty)
                            begin
                                rsp_valid_next = 1'b0;
                                if (cum_arr[0] != '0)
                                begin
                                    cmd.op = OP_DEC;
                                end
                            end
                        end
                        FUNC_SLEEP:
                        begin
                            if (full)
                            begin
                                kind_next = KIND_FULL;
                            end
                            else
                            begin
                                cmd.op = OP_INSERT;
                            end
                        end
                        FUNC_REMOVE:
                        begin
                            cmd.op = OP_REMOVE;
                            if (!found)
                            begin
                                kind_next = KIND_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            kind_next = KIND_DONE;
                        end
                    endcase
                end
            end
            ST_WAKE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (head_zero)
                    begin
                        cmd.op        = OP_POP;
                        kind_next     = KIND_WOKEN;
                        woken_id_next = thread_arr[0];
                        last_next     = wake_last;
                        wake_cnt_next = wake_cnt_reg + WakeCntW'(1);
                    end
                    else
                    begin
                        kind_next     = KIND_DONE;
                        woken_id_next = '0;
                        last_next     = 1'b1;
                    end
                end
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wake_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wake_cnt_reg  <= wake_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        woken_id_reg <= woken_id_next;
        last_reg     <= last_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign kind      = kind_reg;
    assign woken_id  = woken_id_reg;
    assign last      = last_reg;

    `DLSTQ_ASSERT_SAME(a_wake_blocks_input, clk, rst_n, state_reg == ST_WAKE, !req_ready)
    `DLSTQ_ASSERT_SAME(a_wake_has_head, clk, rst_n, state_reg == ST_WAKE, valid_vec[0])
    `DLSTQ_ASSERT_NEXT(a_insert_grows, clk, rst_n, accept && (func == FUNC_SLEEP) && !full, $countones(valid_vec) == $past($countones(valid_vec)) + 1)
    `DLSTQ_ASSERT_SAME(a_single_is_last, clk, rst_n, rsp_valid_reg && (kind_reg != KIND_WOKEN), last_reg)

endmodule

// ===== tb/delta_list_sleep_timer_queue_unit_tb.sv =====
// Self-checking testbench for delta_list_sleep_timer_queue_unit: directed and random
// sleep/remove/tick items, checked against an in-bench delta-list predictor.
// Depends on dlstq_pkg and the RTL top level only.
`timescale 1ns / 100ps

module delta_list_sleep_timer_queue_unit_tb;
    import dlstq_pkg::*;

    localparam int SLEEP_SLOTS = DefaultMaxSleepers;
    localparam int MAX_WAKES   = MaxResults;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ID_W-1:0]    thread;
        logic [TICKS_W-1:0] ticks;
    } timer_req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic              last;
    } timer_reply_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic [FUNC_W-1:0]   func = '0;
    logic [ID_W-1:0]     thread_id = '0;
    logic [TICKS_W-1:0]  sleep_ticks = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     woken_id;
    logic                last;

    timer_req_t   request_backlog[$];
    timer_reply_t pending_replies[$];
    timer_reply_t want;

    logic [ID_W-1:0]    sleeper_thread [SLEEP_SLOTS];
    logic [TICKS_W-1:0] sleeper_delta  [SLEEP_SLOTS];
    int                 sleeper_count = 0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int error_count = 0;

    delta_list_sleep_timer_queue_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .func        (func),
        .thread_id   (thread_id),
        .sleep_ticks (sleep_ticks),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .kind        (kind),
        .woken_id    (woken_id),
        .last        (last)
    );

    always #5 clk = ~clk;

    task automatic flag_mismatch(input string what);
        if (error_count < 40)
        begin
            $display("ERROR at %0t: %s", $time, what);
        end
        error_count++;
    endtask

    function automatic void queue_reply(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] id,
                                        input logic lst);
        timer_reply_t r;
        r.kind = k;
        r.id   = id;
        r.last = lst;
        pending_replies.push_back(r);
    endfunction

    function automatic void queue_request(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                                          input logic [TICKS_W-1:0] t);
        timer_req_t rq;
        rq.func   = f;
        rq.thread = id;
        rq.ticks  = t;
        request_backlog.push_back(rq);
    endfunction

    task automatic drop_slot(input int pos);
        int j;
        for (j = pos; j + 1 < sleeper_count; j++)
        begin
            sleeper_thread[j] = sleeper_thread[j + 1];
            sleeper_delta[j]  = sleeper_delta[j + 1];
        end
        sleeper_count--;
    endtask

    // Advance the sleep list by one accepted item and queue the replies it causes.
    task automatic advance_sleep_list(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                                      input logic [TICKS_W-1:0] t);
        int                 pos;
        int                 j;
        int                 n;
        int                 hit;
        logic               more;
        logic [ID_W-1:0]    head_id;
        logic [TICKS_W-1:0] rem;
        logic [TICKS_W:0]   sum;
        case (f)
            FUNC_TICK:
            begin
                if (sleeper_count == 0)
                begin
                    queue_reply(KIND_DONE, '0, 1'b1);
                end
                else
                begin
                    if (sleeper_delta[0] != 0)
                    begin
                        sleeper_delta[0] = sleeper_delta[0] - 1'b1;
                    end
                    n = 0;
                    while (n < MAX_WAKES && sleeper_count > 0 && sleeper_delta[0] == 0)
                    begin
                        head_id = sleeper_thread[0];
                        drop_slot(0);
                        n++;
                        more = (n < MAX_WAKES && sleeper_count > 0 && sleeper_delta[0] == 0);
                        queue_reply(KIND_WOKEN, head_id, !more);
                    end
                    if (n == 0)
                    begin
                        queue_reply(KIND_DONE, '0, 1'b1);
                    end
                end
            end
            FUNC_SLEEP:
            begin
                if (sleeper_count >= SLEEP_SLOTS)
                begin
                    queue_reply(KIND_FULL, '0, 1'b1);
                end
                else
                begin
                    rem = t;
                    pos = 0;
                    while (pos < sleeper_count && rem >= sleeper_delta[pos])
                    begin
                        rem = rem - sleeper_delta[pos];
                        pos++;
                    end
                    for (j = sleeper_count; j > pos; j--)
                    begin
                        sleeper_thread[j] = sleeper_thread[j - 1];
                        sleeper_delta[j]  = sleeper_delta[j - 1];
                    end
                    sleeper_thread[pos] = id;
                    sleeper_delta[pos]  = rem;
                    sleeper_count++;
                    if (pos + 1 < sleeper_count)
                    begin
                        sleeper_delta[pos + 1] = sleeper_delta[pos + 1] - rem;
                    end
                    queue_reply(KIND_DONE, '0, 1'b1);
                end
            end
            FUNC_REMOVE:
            begin
                hit = -1;
                for (pos = 0; pos < sleeper_count; pos++)
                begin
                    if (hit < 0 && sleeper_thread[pos] == id)
                    begin
                        hit = pos;
                    end
                end
                if (hit < 0)
                begin
                    queue_reply(KIND_NOT_FOUND, '0, 1'b1);
                end
                else
                begin
                    if (hit + 1 < sleeper_count)
                    begin
                        sum = {1'b0, sleeper_delta[hit + 1]} + {1'b0, sleeper_delta[hit]};
                        sleeper_delta[hit + 1] = sum[TICKS_W] ? '1 : sum[TICKS_W-1:0];
                    end
                    drop_slot(hit);
                    queue_reply(KIND_DONE, '0, 1'b1);
                end
            end
            default:
            begin
                queue_reply(KIND_DONE, '0, 1'b1);
            end
        endcase
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid   <= 1'b0;
            func        <= '0;
            thread_id   <= '0;
            sleep_ticks <= '0;
        end
        else if (req_valid && !req_ready)
        begin
            req_valid <= 1'b1;
        end
        else if (request_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
        begin
            req_valid   <= 1'b1;
            func        <= request_backlog[0].func;
            thread_id   <= request_backlog[0].thread;
            sleep_ticks <= request_backlog[0].ticks;
            void'(request_backlog.pop_front());
        end
        else
        begin
            req_valid <= 1'b0;
        end
    end

    // Response back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Monitor and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                advance_sleep_list(func, thread_id, sleep_ticks);
            end
            if (rsp_valid && rsp_ready)
            begin
                if (pending_replies.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected item kind=%0d id=%0d last=%0d",
                                            kind, woken_id, last));
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (kind !== want.kind)
                    begin
                        flag_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
                    end
                    if (woken_id !== want.id)
                    begin
                        flag_mismatch($sformatf("woken_id %0d, expected %0d",
                                                woken_id, want.id));
                    end
                    if (last !== want.last)
                    begin
                        flag_mismatch($sformatf("last %0d, expected %0d", last, want.last));
                    end
                end
            end
        end
    end

    initial
    begin
        int               phase;
        int               k;
        int               pick;
        logic [ID_W-1:0]  id;
        logic [TICKS_W-1:0] ticks;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty list, absent thread, unused code, extremes, ties, duplicates
        queue_request(FUNC_TICK, 8'hA5, 16'h5A5A);
        queue_request(FUNC_REMOVE, 8'd5, 16'd0);
        queue_request(FUNC_UNUSED, 8'hFF, 16'hFFFF);
        queue_request(FUNC_SLEEP, 8'hFF, 16'hFFFF);
        queue_request(FUNC_SLEEP, 8'h00, 16'd0);
        queue_request(FUNC_SLEEP, 8'd1, 16'd1);
        queue_request(FUNC_SLEEP, 8'd2, 16'd1);
        queue_request(FUNC_SLEEP, 8'd1, 16'd3);
        queue_request(FUNC_REMOVE, 8'd1, 16'd0);
        queue_request(FUNC_TICK, 8'd0, 16'd0);
        // fill to overflow, then two ticks; the second wakes most of the list at once
        for (k = 0; k < 16; k++)
        begin
            queue_request(FUNC_SLEEP, 8'h10 + 8'(k), 16'd2);
        end
        queue_request(FUNC_TICK, 8'd0, 16'd0);
        queue_request(FUNC_TICK, 8'd0, 16'd0);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 78; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 78; end
                default: begin send_idle_pct = 28; stall_pct = 28; end
            endcase
            for (k = 0; k < 52; k++)
            begin
                pick  = $urandom_range(0, 99);
                id    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
                ticks = 16'($urandom);
                if (pick < 45)
                begin
                    if ($urandom_range(0, 24) != 0)
                    begin
                        ticks = 16'($urandom_range(1, 6));
                    end
                    queue_request(FUNC_SLEEP, id, ticks);
                end
                else if (pick < 62)
                begin
                    queue_request(FUNC_REMOVE, id, ticks);
                end
                else if (pick < 65)
                begin
                    queue_request(FUNC_UNUSED, id, ticks);
                end
                else
                begin
                    queue_request(FUNC_TICK, id, ticks);
                end
            end
            while (request_backlog.size() > 0)
            begin
                @(negedge clk);
            end
        end

        while (request_backlog.size() > 0 || req_valid || pending_replies.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== delta_list_sleep_timer_queue_unit.f =====
+incdir+sv
sv/dlstq_pkg.sv
sv/dlstq_cell.sv
sv/delta_list_sleep_timer_queue_unit.sv
tb/delta_list_sleep_timer_queue_unit_tb.sv
